@@ rtl/assert_macros.svh @@
// assertion macros shared by the stack rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/blifo_pkg.sv @@
// types and constants for the bounded lifo stack
// no dependencies; imported by the controller, datapath and top level
package blifo_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic             REG_LIMIT_IDX = 1'b0;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_INC   = 2'd1,
    CNT_DEC   = 2'd2,
    CNT_CLEAR = 2'd3
  } cnt_op_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_PUSH = 2'd1,
    WR_LO   = 2'd2,
    WR_HI   = 2'd3
  } wr_op_e;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_TOP  = 2'd1,
    RD_PAIR = 2'd2
  } rd_op_e;

  typedef struct packed {
    cnt_op_e              cnt_op;
    wr_op_e               wr_op;
    rd_op_e               rd_op;
    logic                 ptr_init;
    logic                 ptr_step;
    logic                 res_load;
    logic                 res_from_ram;
    logic [STATUS_W-1:0]  res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic few;
    logic pair_left;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/blifo_ram.sv @@
// generic single write, dual read ram with registered read data
// no dependencies
module blifo_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/blifo_ctrl.sv @@
// controller state machine for the bounded lifo stack
// depends on blifo_pkg and assert_macros.svh
`include "assert_macros.svh"

module blifo_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  logic [blifo_pkg::CMD_W-1:0]       op_i,
  input  blifo_pkg::dp_stat_t               dp_stat_i,
  output blifo_pkg::dp_cmd_t                dp_cmd_o
);

  import blifo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_REV_RD = 5'b00100,
    S_WR_LO  = 5'b01000,
    S_WR_HI  = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  logic    pop_q, pop_d;
  dp_cmd_t dp_cmd;
  logic    accept;

  assign accept = s_valid_i && s_ready_o;

  always_comb begin
    state_d             = state_q;
    pop_d               = pop_q;
    s_ready_o           = 1'b0;
    dp_cmd              = '0;
    dp_cmd.cnt_op       = CNT_HOLD;
    dp_cmd.wr_op        = WR_NONE;
    dp_cmd.rd_op        = RD_NONE;
    dp_cmd.res_status   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = dp_stat_i.out_free;
        if (s_valid_i && dp_stat_i.out_free) begin
          unique case (op_i) inside
            CMD_PUSH: begin
              dp_cmd.res_load = 1'b1;
              if (dp_stat_i.full) begin
                dp_cmd.res_status = ST_OVERFLOW;
              end else begin
                dp_cmd.wr_op  = WR_PUSH;
                dp_cmd.cnt_op = CNT_INC;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (dp_stat_i.empty) begin
                dp_cmd.res_load   = 1'b1;
                dp_cmd.res_status = ST_UNDERFLOW;
              end else begin
                dp_cmd.rd_op = RD_TOP;
                pop_d        = (op_i == CMD_POP);
                state_d      = S_READ;
              end
            end
            CMD_REVERSE: begin
              if (dp_stat_i.few) begin
                dp_cmd.res_load = 1'b1;
              end else begin
                dp_cmd.ptr_init = 1'b1;
                state_d         = S_REV_RD;
              end
            end
            CMD_CLEAR: begin
              dp_cmd.cnt_op   = CNT_CLEAR;
              dp_cmd.res_load = 1'b1;
            end
            default: begin
              dp_cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        dp_cmd.res_load     = 1'b1;
        dp_cmd.res_from_ram = 1'b1;
        dp_cmd.cnt_op       = pop_q ? CNT_DEC : CNT_HOLD;
        state_d             = S_IDLE;
      end
      S_REV_RD: begin
        if (dp_stat_i.pair_left) begin
          dp_cmd.rd_op = RD_PAIR;
          state_d      = S_WR_LO;
        end else begin
          dp_cmd.res_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_WR_LO: begin
        dp_cmd.wr_op = WR_LO;
        state_d      = S_WR_HI;
      end
      S_WR_HI: begin
        dp_cmd.wr_op    = WR_HI;
        dp_cmd.ptr_step = 1'b1;
        state_d         = S_REV_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

  assign dp_cmd_o = dp_cmd;

  `ASSERT_AT(a_result_slot_free, dp_cmd.res_load |-> dp_stat_i.out_free, "result overwritten")
  `ASSERT_AT(a_swap_in_range, (state_q == S_WR_LO) |-> $past(dp_stat_i.pair_left), "bad swap")
  `ASSERT_NEVER(a_accept_while_busy, accept && (state_q != S_IDLE), "accept while busy")

endmodule

@@ rtl/blifo_dp.sv @@
// datapath for the bounded lifo stack: count, swap pointers, entry ram, result register
// depends on blifo_pkg, blifo_ram and assert_macros.svh
`include "assert_macros.svh"

module blifo_dp #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  blifo_pkg::dp_cmd_t                 dp_cmd_i,
  output blifo_pkg::dp_stat_t                dp_stat_o,
  input  logic [blifo_pkg::COUNT_W-1:0]      limit_i,
  input  logic [blifo_pkg::WORD_W-1:0]       push_value_i,
  input  logic                               m_ready_i,
  output logic                               out_valid_o,
  output logic [blifo_pkg::WORD_W-1:0]       read_value_o,
  output logic [blifo_pkg::STATUS_W-1:0]     status_o,
  output logic [blifo_pkg::COUNT_W-1:0]      entry_count_o
);

  import blifo_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [AW-1:0]         lo_q, lo_d;
  logic [AW-1:0]         hi_q, hi_d;
  logic                  out_valid_q, out_valid_d;
  logic [WORD_W-1:0]     read_value_q;
  logic [STATUS_W-1:0]   status_q;
  logic [COUNT_W-1:0]    entry_count_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re_a;
  logic                  ram_re_b;
  logic [AW-1:0]         ram_raddr_a;
  logic [DATA_WIDTH-1:0] ram_rdata_a;
  logic [DATA_WIDTH-1:0] ram_rdata_b;
  logic [AW-1:0]         top_addr;

  assign top_addr = AW'(count_q - 1'b1);

  assign dp_stat_o.empty     = (count_q == '0);
  assign dp_stat_o.full      = (CMP_W'(count_q) >= CMP_W'(limit_i)) ||
                               (count_q == CNT_W'(DEPTH));
  assign dp_stat_o.few       = (count_q < CNT_W'(2));
  assign dp_stat_o.pair_left = (hi_q > lo_q);
  assign dp_stat_o.out_free  = !out_valid_q || m_ready_i;

  always_comb begin
    unique case (dp_cmd_i.cnt_op)
      CNT_INC:   count_d = count_q + 1'b1;
      CNT_DEC:   count_d = count_q - 1'b1;
      CNT_CLEAR: count_d = '0;
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (dp_cmd_i.ptr_init) begin
      lo_d = '0;
      hi_d = top_addr;
    end else if (dp_cmd_i.ptr_step) begin
      lo_d = lo_q + 1'b1;
      hi_d = hi_q - 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_q;
    ram_wdata = ram_rdata_b;
    unique case (dp_cmd_i.wr_op)
      WR_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(count_q);
        ram_wdata = DATA_WIDTH'(push_value_i);
      end
      WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = ram_rdata_b;
      end
      WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = ram_rdata_a;
      end
      default: ;
    endcase
  end

  assign ram_re_a    = (dp_cmd_i.rd_op == RD_TOP) || (dp_cmd_i.rd_op == RD_PAIR);
  assign ram_re_b    = (dp_cmd_i.rd_op == RD_PAIR);
  assign ram_raddr_a = (dp_cmd_i.rd_op == RD_PAIR) ? lo_q : top_addr;

  blifo_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (ram_re_a),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .re_b_i    (ram_re_b),
    .raddr_b_i (hi_q),
    .rdata_b_o (ram_rdata_b)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_ready_i;
    if (dp_cmd_i.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (dp_cmd_i.res_load) begin
      read_value_q  <= dp_cmd_i.res_from_ram ? WORD_W'(ram_rdata_a) : '0;
      status_q      <= dp_cmd_i.res_status;
      entry_count_q <= COUNT_W'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

  `ASSERT_AT(a_push_has_room, (dp_cmd_i.wr_op == WR_PUSH) |-> !dp_stat_o.full, "push when full")
  `ASSERT_AT(a_pop_has_entry, (dp_cmd_i.cnt_op == CNT_DEC) |-> !dp_stat_o.empty, "pop when empty")

endmodule

@@ rtl/bounded_lifo_stack.sv @@
// bounded lifo stack, top level: stream ports, apb limit register, controller and datapath
// depends on blifo_pkg, blifo_ctrl, blifo_dp and blifo_ram
//
// A last-in-first-out stack of up to DEPTH words of DATA_WIDTH bits, held in a ram with
// registered read. Each input transaction carries a command (push, pop, peek, reverse,
// clear) and gives exactly one result transaction with the word read, a status
// (ok, overflow, underflow) and the entry count after the command. The fill limit is the
// apb register at byte address 0 (reset 64), capped at DEPTH. The user must write it only
// while the block is idle; the block does not enforce this. Items are taken one at a time:
// push, clear, unknown commands, errors and reverse of under two entries finish in the
// idle state, pop and peek pass through a read state as the top entry comes through the
// ram read register, and reverse does one read of both ends and two writes through the
// single ram write port per swapped pair. The result stays in an output register, and the
// next item is taken no earlier than the cycle in which that result is taken, so a stalled
// result stalls the input. The ram has no reset and needs none.
module bounded_lifo_stack #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: [2:0] cmd, [34:3] push_value, [39:35] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // master side: [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import blifo_pkg::*;

  logic [COUNT_W-1:0]  limit_q;
  logic [COUNT_W-1:0]  limit_d;
  logic                cfg_write;
  logic                limit_sel;
  dp_cmd_t             dp_cmd;
  dp_stat_t            dp_stat;
  logic [CMD_W-1:0]    op;
  logic [WORD_W-1:0]   push_value;
  logic [WORD_W-1:0]   read_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  assign pready    = 1'b1;
  assign limit_sel = (paddr[2] == REG_LIMIT_IDX);
  assign cfg_write = psel && penable && pwrite && pready && limit_sel;
  assign limit_d   = cfg_write ? pwdata[COUNT_W-1:0] : limit_q;
  assign prdata    = limit_sel ? {{(32 - COUNT_W){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign op         = s_axis_tdata[CMD_W-1:0];
  assign push_value = s_axis_tdata[CMD_W+WORD_W-1:CMD_W];

  blifo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .op_i      (op),
    .dp_stat_i (dp_stat),
    .dp_cmd_o  (dp_cmd)
  );

  blifo_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .dp_stat_o     (dp_stat),
    .limit_i       (limit_q),
    .push_value_i  (push_value),
    .m_ready_i     (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .read_value_o  (read_value),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {7'b0, entry_count, status, read_value};

endmodule
